// File: sv/bresenham_line_rasterizer_top_macros.svh
// assertion helpers for the line rasterizer
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication
`define BLR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BLR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/blr_pkg.sv
package blr_pkg;

	localparam int COORD_BITS   = 6;
	localparam int CFG_BITS     = COORD_BITS + 1;
	localparam int CFG_IDX_BITS = 2;
	localparam int ERR_BITS     = COORD_BITS + 2;
	localparam int WIDE_BITS    = COORD_BITS + 3;

	localparam logic [CFG_BITS-1:0] CANVAS_WIDTH_RST  = CFG_BITS'(60);
	localparam logic [CFG_BITS-1:0] CANVAS_HEIGHT_RST = CFG_BITS'(30);

	localparam logic GLYPH_STAR       = 1'b0;
	localparam logic GLYPH_UNDERSCORE = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CANVAS_WIDTH  = 2'd0,
		CFG_CANVAS_HEIGHT = 2'd1
	} cfg_index_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
	} line_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] point_x;
		logic [COORD_BITS-1:0] point_y;
		logic                  glyph;
		logic                  visible;
		logic                  last_point;
	} point_t;

	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic at_end;
	} dp_status_t;

endpackage

// File: sv/bresenham_line_rasterizer_top.sv
// Line rasterizer: takes two endpoints and emits every point of the segment.
// item channel (item_valid/item_ready/item): one transaction per line, with
//   x_start, y_start, x_end, y_end.
// point channel (point_valid/point_ready/point): one transaction per point,
//   start to end inclusive, with glyph, canvas visibility and a last_point mark.
// Configuration: cfg_we with cfg_index 0 writes canvas_width, 1 writes
//   canvas_height; other indexes are ignored. Write only while no line is open.
// Latency: the first point is valid the cycle after the line is taken.
// Throughput: one point per cycle from the single error-term stepping unit;
//   a line has max(|dx|,|dy|)+1 points, at most 64. A new line is taken in
//   the cycle its predecessor's last point is taken, so lines run back to back.
// When point_ready is low the current point holds and the walk pauses.
// Reset: the walk returns to idle, canvas size becomes 60 by 30.
module bresenham_line_rasterizer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  blr_pkg::line_t                   item,
	output logic                             point_valid,
	input  logic                             point_ready,
	output blr_pkg::point_t                  point,
	input  logic                             cfg_we,
	input  logic [blr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [blr_pkg::CFG_BITS-1:0]     cfg_wdata
);

	blr_pkg::dp_cmd_t    cmd;
	blr_pkg::dp_status_t status;

	blr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.status      (status),
		.cmd         (cmd)
	);

	blr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.point     (point)
	);

endmodule

// File: sv/blr_ctrl.sv
module blr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                point_valid,
	input  logic                point_ready,
	input  blr_pkg::dp_status_t status,
	output blr_pkg::dp_cmd_t    cmd
);

	blr_pkg::state_t state_q, state_nxt;
	logic            finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		point_valid = 1'b0;
		finish      = 1'b0;
		cmd.step    = 1'b0;
		unique case (state_q)
			blr_pkg::ST_IDLE: begin
				point_valid = 1'b0;
			end
			blr_pkg::ST_RUN: begin
				point_valid = 1'b1;
				finish      = point_ready && status.at_end;
				cmd.step    = point_ready && !status.at_end;
				if (finish) begin
					state_nxt = blr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = blr_pkg::ST_IDLE;
			end
		endcase
		// a new line may start in the cycle the last point leaves
		item_ready = (state_q == blr_pkg::ST_IDLE) || finish;
		cmd.load   = item_valid && item_ready;
		if (cmd.load) begin
			state_nxt = blr_pkg::ST_RUN;
		end
	end

endmodule

// File: sv/blr_datapath.sv
module blr_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  blr_pkg::dp_cmd_t                     cmd,
	output blr_pkg::dp_status_t                  status,
	input  blr_pkg::line_t                       item,
	input  logic                                 cfg_we,
	input  logic [blr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [blr_pkg::CFG_BITS-1:0]         cfg_wdata,
	output blr_pkg::point_t                      point
);

	localparam int CB = blr_pkg::COORD_BITS;
	localparam int EB = blr_pkg::ERR_BITS;
	localparam int WB = blr_pkg::WIDE_BITS;

	logic [blr_pkg::CFG_BITS-1:0] canvas_width_q, canvas_height_q;

	logic [CB-1:0]        cur_x_q, cur_y_q, goal_x_q, goal_y_q, delta_x_q, delta_y_q;
	logic signed [EB-1:0] err_q;
	logic                 step_x_neg_q, step_y_neg_q, horizontal_q;

	logic                 ld_x_neg, ld_y_neg;
	logic [CB-1:0]        ld_dx, ld_dy;
	logic signed [WB-1:0] e2, dx_w, dy_w, err_w, err_nxt;
	logic                 move_x, move_y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= blr_pkg::CANVAS_WIDTH_RST;
			canvas_height_q <= blr_pkg::CANVAS_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (blr_pkg::cfg_index_t'(cfg_index))
				blr_pkg::CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_wdata;
				blr_pkg::CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// setup of a new line
	always_comb begin
		ld_x_neg = !(item.x_start < item.x_end);
		ld_y_neg = !(item.y_start < item.y_end);
		ld_dx    = ld_x_neg ? item.x_start - item.x_end : item.x_end - item.x_start;
		ld_dy    = ld_y_neg ? item.y_start - item.y_end : item.y_end - item.y_start;
	end

	// error term step
	always_comb begin
		dx_w    = signed'(WB'(delta_x_q));
		dy_w    = signed'(WB'(delta_y_q));
		err_w   = WB'(err_q);
		e2      = err_w <<< 1;
		move_x  = e2 > -dy_w;
		move_y  = e2 < dx_w;
		err_nxt = err_w - (move_x ? dy_w : '0) + (move_y ? dx_w : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			delta_x_q    <= '0;
			delta_y_q    <= '0;
			err_q        <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			horizontal_q <= 1'b0;
		end else if (cmd.load) begin
			cur_x_q      <= item.x_start;
			cur_y_q      <= item.y_start;
			goal_x_q     <= item.x_end;
			goal_y_q     <= item.y_end;
			delta_x_q    <= ld_dx;
			delta_y_q    <= ld_dy;
			err_q        <= signed'(EB'(ld_dx)) - signed'(EB'(ld_dy));
			step_x_neg_q <= ld_x_neg;
			step_y_neg_q <= ld_y_neg;
			horizontal_q <= (ld_dy == '0);
		end else if (cmd.step) begin
			err_q <= EB'(err_nxt);
			if (move_x) begin
				cur_x_q <= step_x_neg_q ? cur_x_q - CB'(1) : cur_x_q + CB'(1);
			end
			if (move_y) begin
				cur_y_q <= step_y_neg_q ? cur_y_q - CB'(1) : cur_y_q + CB'(1);
			end
		end
	end

	assign status.at_end = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);

	always_comb begin
		point.point_x    = cur_x_q;
		point.point_y    = cur_y_q;
		point.glyph      = horizontal_q ? blr_pkg::GLYPH_UNDERSCORE : blr_pkg::GLYPH_STAR;
		point.visible    = ({1'b0, cur_x_q} < canvas_width_q)
			&& ({1'b0, cur_y_q} < canvas_height_q);
		point.last_point = status.at_end;
	end

endmodule

// File: sv/blr_checker.sv
`include "bresenham_line_rasterizer_top_macros.svh"

module blr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input blr_pkg::line_t                   item,
	input logic                             point_valid,
	input logic                             point_ready,
	input blr_pkg::point_t                  point,
	input logic                             cfg_we,
	input logic [blr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [blr_pkg::CFG_BITS-1:0]     cfg_wdata
);

	`BLR_ASSERT_NXT(a_point_hold, point_valid && !point_ready, point_valid && $stable(point), "stalled point changed")
	`BLR_ASSERT_NXT(a_first_point, item_valid && item_ready, point_valid && point.point_x == $past(item.x_start) && point.point_y == $past(item.y_start), "first point is not the start")
	`BLR_ASSERT_NXT(a_walk_continues, point_valid && point_ready && !point.last_point, point_valid, "line ended before its last point")
	`BLR_ASSERT_IMP(a_ready_overlap, point_valid && item_ready, point_ready && point.last_point, "new line taken while points remain")

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker (.*);

// File: dv/tb_bresenham_line_rasterizer_top.sv
module tb_bresenham_line_rasterizer_top;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 70;
	localparam int CB = blr_pkg::COORD_BITS;
	localparam logic [blr_pkg::CFG_IDX_BITS-1:0] CFG_UNMAPPED_2 = 2'd2;
	localparam logic [blr_pkg::CFG_IDX_BITS-1:0] CFG_UNMAPPED_3 = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	blr_pkg::line_t item = '0;
	logic point_valid;
	logic point_ready = 1'b0;
	blr_pkg::point_t point;
	logic cfg_we = 1'b0;
	logic [blr_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [blr_pkg::CFG_BITS-1:0] cfg_wdata = '0;

	logic [blr_pkg::CFG_BITS-1:0] canvas_w = blr_pkg::CANVAS_WIDTH_RST;
	logic [blr_pkg::CFG_BITS-1:0] canvas_h = blr_pkg::CANVAS_HEIGHT_RST;
	blr_pkg::point_t expected_points[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;
	int ready_hold = 0;
	int stall_len;

	bresenham_line_rasterizer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point      (point),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CB-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > (1 << CB) - 1)
			return '1;
		return v[CB-1:0];
	endfunction

	// expected points of one line, start to end inclusive
	task automatic rasterize_line(input blr_pkg::line_t ln);
		logic [CB-1:0] px, py;
		logic x_neg, y_neg, flat, done;
		int dx, dy, err, e2;
		blr_pkg::point_t pt;
		px = ln.x_start;
		py = ln.y_start;
		x_neg = !(ln.x_start < ln.x_end);
		y_neg = !(ln.y_start < ln.y_end);
		dx = x_neg ? int'(ln.x_start) - int'(ln.x_end) : int'(ln.x_end) - int'(ln.x_start);
		dy = y_neg ? int'(ln.y_start) - int'(ln.y_end) : int'(ln.y_end) - int'(ln.y_start);
		err = dx - dy;
		flat = (dy == 0);
		done = 1'b0;
		while (!done) begin
			done = (px == ln.x_end) && (py == ln.y_end);
			pt.point_x = px;
			pt.point_y = py;
			pt.glyph = flat ? blr_pkg::GLYPH_UNDERSCORE : blr_pkg::GLYPH_STAR;
			pt.visible = (px < canvas_w) && (py < canvas_h);
			pt.last_point = done;
			expected_points.push_back(pt);
			if (!done) begin
				e2 = 2 * err;
				if (e2 > -dy) begin
					err -= dy;
					px = x_neg ? px - 1'b1 : px + 1'b1;
				end
				if (e2 < dx) begin
					err += dx;
					py = y_neg ? py - 1'b1 : py + 1'b1;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			point_ready <= 1'b0;
		end else begin
			stall_len = stall_on ? idle_len() : 0;
			ready_hold <= (stall_len > 0) ? stall_len - 1 : 0;
			point_ready <= (stall_len == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && point_valid && point_ready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected point transaction x=%0d y=%0d", point.point_x, point.point_y);
				mismatch_count++;
			end else begin
				if (point.point_x !== expected_points[0].point_x) begin
					$error("point_x expected %0d got %0d", expected_points[0].point_x,
						point.point_x);
					mismatch_count++;
				end
				if (point.point_y !== expected_points[0].point_y) begin
					$error("point_y expected %0d got %0d", expected_points[0].point_y,
						point.point_y);
					mismatch_count++;
				end
				if (point.glyph !== expected_points[0].glyph) begin
					$error("glyph expected %0d got %0d", expected_points[0].glyph, point.glyph);
					mismatch_count++;
				end
				if (point.visible !== expected_points[0].visible) begin
					$error("visible expected %0d got %0d", expected_points[0].visible,
						point.visible);
					mismatch_count++;
				end
				if (point.last_point !== expected_points[0].last_point) begin
					$error("last_point expected %0d got %0d", expected_points[0].last_point,
						point.last_point);
					mismatch_count++;
				end
				void'(expected_points.pop_front());
			end
		end
	end

	task automatic send_line(input blr_pkg::line_t ln);
		int gap;
		gap = gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= ln;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		rasterize_line(ln);
	endtask

	task automatic send_xy(input int x0, input int y0, input int x1, input int y1);
		blr_pkg::line_t ln;
		ln.x_start = clamp_coord(x0);
		ln.y_start = clamp_coord(y0);
		ln.x_end = clamp_coord(x1);
		ln.y_end = clamp_coord(y1);
		send_line(ln);
	endtask

	// wait until every expected point has come and the block is idle
	task automatic drain();
		item_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [blr_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [blr_pkg::CFG_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx == blr_pkg::CFG_CANVAS_WIDTH)
			canvas_w = value;
		else if (idx == blr_pkg::CFG_CANVAS_HEIGHT)
			canvas_h = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic blr_pkg::line_t random_line();
		blr_pkg::line_t ln;
		int d;
		ln.x_start = CB'($urandom_range(0, 63));
		ln.y_start = CB'($urandom_range(0, 63));
		ln.x_end = CB'($urandom_range(0, 63));
		ln.y_end = CB'($urandom_range(0, 63));
		case ($urandom_range(0, 9))
			4: ln.y_end = ln.y_start;
			5: ln.x_end = ln.x_start;
			6: begin
				d = int'(ln.x_end) - int'(ln.x_start);
				if (int'(ln.y_start) + d >= 0 && int'(ln.y_start) + d <= 63)
					ln.y_end = CB'(int'(ln.y_start) + d);
				else
					ln.y_end = clamp_coord(int'(ln.y_start) - d);
			end
			7: begin
				ln.x_end = clamp_coord(int'(ln.x_start) + int'($urandom_range(0, 6)) - 3);
				ln.y_end = clamp_coord(int'(ln.y_start) + int'($urandom_range(0, 6)) - 3);
			end
			8: begin
				ln.x_end = ln.x_start;
				ln.y_end = ln.y_start;
			end
			default: ;
		endcase
		return ln;
	endfunction

	task automatic test_fixed_lines();
		send_xy(0, 0, 0, 0);
		send_xy(63, 63, 63, 63);
		send_xy(0, 0, 63, 0);
		send_xy(63, 63, 0, 63);
		send_xy(0, 0, 0, 63);
		send_xy(5, 63, 5, 0);
		send_xy(0, 0, 63, 63);
		send_xy(63, 0, 0, 63);
		send_xy(10, 2, 13, 40);
		send_xy(50, 28, 3, 31);
		send_xy(21, 42, 42, 21);
	endtask

	task automatic test_canvas_limits();
		drain();
		write_reg(blr_pkg::CFG_CANVAS_WIDTH, 7'd64);
		write_reg(blr_pkg::CFG_CANVAS_HEIGHT, 7'd64);
		send_xy(0, 0, 63, 63);
		send_xy(63, 0, 0, 63);
		drain();
		// zero canvas hides everything
		write_reg(blr_pkg::CFG_CANVAS_WIDTH, 7'd0);
		write_reg(blr_pkg::CFG_CANVAS_HEIGHT, 7'd0);
		send_xy(0, 0, 0, 0);
		send_xy(7, 9, 30, 1);
		drain();
		write_reg(blr_pkg::CFG_CANVAS_WIDTH, 7'd127);
		write_reg(blr_pkg::CFG_CANVAS_HEIGHT, 7'd127);
		send_xy(63, 31, 0, 32);
		drain();
		write_reg(blr_pkg::CFG_CANVAS_WIDTH, 7'd1);
		write_reg(blr_pkg::CFG_CANVAS_HEIGHT, 7'd1);
		// unmapped indexes must not touch the canvas size
		write_reg(CFG_UNMAPPED_3, 7'd0);
		write_reg(CFG_UNMAPPED_2, 7'd127);
		send_xy(0, 0, 2, 1);
		send_xy(1, 1, 1, 1);
	endtask

	task automatic test_back_to_back();
		drain();
		write_reg(blr_pkg::CFG_CANVAS_WIDTH, blr_pkg::CANVAS_WIDTH_RST);
		write_reg(blr_pkg::CFG_CANVAS_HEIGHT, blr_pkg::CANVAS_HEIGHT_RST);
		gaps_on = 1'b0;
		stall_on = 1'b0;
		repeat (20) send_line(random_line());
		gaps_on = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		for (int round = 0; round < 4; round++) begin
			drain();
			write_reg(blr_pkg::CFG_CANVAS_WIDTH, 7'($urandom_range(1, 64)));
			write_reg(blr_pkg::CFG_CANVAS_HEIGHT, 7'($urandom_range(1, 64)));
			repeat (20) send_line(random_line());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fixed_lines();
		test_canvas_limits();
		test_back_to_back();
		test_random_traffic();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
